[design/aae_pkg.sv]
// Shared constants for the adaptive arithmetic encoder.
// No dependencies; imported by the divider and the top level.
package aae_pkg;

    // Width of a symbol count and of a cumulative count.
    localparam int CNT_W = 14;
    // Width of the pending underflow bit counter.
    localparam int PEND_W = 8;
    // Width of a code byte and of the raw input byte.
    localparam int BYTE_W = 8;
    // Depth of the byte-to-rank table: one entry per byte value.
    localparam int B2R_DEPTH = 256;
    // Most code bytes that one transaction can produce.
    localparam int MAX_RESULTS = 36;
    localparam int RES_AW = $clog2(MAX_RESULTS);
    localparam int RES_CW = $clog2(MAX_RESULTS + 1);

    // Input operation codes.
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

endpackage

[design/adaptive_arithmetic_encoder_core.sv]
// Adaptive order-0 arithmetic encoder, one transaction at a time: s_ready is high only when idle.
// Coding a data byte reads the model, runs two bit-serial divisions, then renormalizes step by
// step, each emitted and pending bit in its own state; the model update follows, with a rescale
// once the total reaches FREQ_LIMIT; code bytes then leave one at a time from the result buffer.
// The one read port of each model memory and the bit-serial divider keep these steps sequential.
// After reset and after each finish, a clearing pass reloads the model memories while s_ready stays low.
module adaptive_arithmetic_encoder_core
    import aae_pkg::*;
#(
    parameter int CODE_BITS     = 16,
    parameter int FREQ_LIMIT    = 16383,
    parameter int ALPHABET      = 256,
    parameter int PENDING_LIMIT = 255
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_last,
    output logic              m_pending_overflow
);

    // Model geometry. Rank NSYM is the end symbol; rank 0 holds the total.
    localparam int NSYM     = ALPHABET + 1;
    localparam int TDEPTH   = ALPHABET + 2;
    localparam int RANK_W   = $clog2(TDEPTH);
    localparam int CB       = CODE_BITS;
    localparam int PROD_W   = CB + 1 + CNT_W;
    localparam int GUARD_W  = $clog2(CB + 3);
    localparam int CLR_LAST = (TDEPTH > B2R_DEPTH) ? TDEPTH - 1 : B2R_DEPTH - 1;
    localparam int CLR_W    = $clog2(CLR_LAST + 1);

    localparam logic [CB-1:0] TOP_VAL  = {CB{1'b1}};
    localparam logic [CB-1:0] HALF_VAL = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] QTR_VAL  = {2'b01, {(CB-2){1'b0}}};
    localparam logic [CB-1:0] QTR3_VAL = {2'b11, {(CB-2){1'b0}}};
    localparam logic [RANK_W-1:0] NSYM_R = RANK_W'(NSYM);
    localparam logic [GUARD_W-1:0] GUARD_MAX = GUARD_W'(CB + 2);

    typedef enum logic [34:0] {
        S_CLR    = 35'h000000001,
        S_IDLE   = 35'h000000002,
        S_MAP    = 35'h000000004,
        S_MAPW   = 35'h000000008,
        S_RC0    = 35'h000000010,
        S_RC1    = 35'h000000020,
        S_RC2    = 35'h000000040,
        S_RC3    = 35'h000000080,
        S_MUL1   = 35'h000000100,
        S_DS1    = 35'h000000200,
        S_DW1    = 35'h000000400,
        S_MUL2   = 35'h000000800,
        S_DS2    = 35'h000001000,
        S_DW2    = 35'h000002000,
        S_INT    = 35'h000004000,
        S_REN    = 35'h000008000,
        S_EMIT   = 35'h000010000,
        S_PEND   = 35'h000020000,
        S_FADD   = 35'h000040000,
        S_FLUSH  = 35'h000080000,
        S_UPD    = 35'h000100000,
        S_RSC_RD = 35'h000200000,
        S_RSC_WR = 35'h000400000,
        S_SCR    = 35'h000800000,
        S_SCW    = 35'h001000000,
        S_WALK   = 35'h002000000,
        S_SW     = 35'h004000000,
        S_SW_R1  = 35'h008000000,
        S_SW_R2  = 35'h010000000,
        S_SW_W1  = 35'h020000000,
        S_SW_W2  = 35'h040000000,
        S_SCINC  = 35'h080000000,
        S_INC    = 35'h100000000,
        S_ORD    = 35'h200000000,
        S_OLD    = 35'h400000000
    } state_t;

    state_t state_reg, state_next;

    // Item and coder registers.
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              seen_reg;
    logic              ovf_reg;
    logic [RANK_W-1:0] s_reg;
    logic [CNT_W-1:0]  c_prev_reg;
    logic [CNT_W-1:0]  c_cur_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CB-1:0]     q1_reg;
    logic [CB-1:0]     q2_reg;
    logic [CB-1:0]     lo_reg;
    logic [CB-1:0]     hi_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              bit_reg;
    logic              fin_emit_reg;
    logic [BYTE_W-1:0] buf_reg;
    logic [2:0]        cnt_reg;
    logic [RES_CW-1:0] res_n_reg;
    logic [RES_CW-1:0] out_idx_reg;
    logic [CLR_W-1:0]  clr_idx_reg;

    // Model update registers.
    logic [RANK_W-1:0] k_reg;
    logic [CNT_W-1:0]  acc_reg;
    logic [CNT_W-1:0]  sc_s_reg;
    logic [RANK_W-1:0] cur_reg;
    logic [RANK_W-1:0] idx_reg;
    logic [BYTE_W-1:0] bi_reg;
    logic [BYTE_W-1:0] bs_reg;

    // Output register.
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_out_byte_reg;
    logic              m_last_reg;
    logic              m_ovf_reg;

    // Memory ports.
    logic              sc_we, cum_we, rb_we, b2r_we, res_we;
    logic [RANK_W-1:0] sc_waddr, sc_raddr, cum_waddr, cum_raddr, rb_waddr, rb_raddr;
    logic [CNT_W-1:0]  sc_wdata, sc_rdata, cum_wdata, cum_rdata;
    logic [BYTE_W-1:0] rb_wdata, rb_rdata, b2r_waddr, res_wdata, res_rdata;
    logic [RANK_W-1:0] b2r_wdata, b2r_rdata;
    logic [RES_AW-1:0] res_waddr;

    // Divider.
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] div_quot;
    logic [CNT_W-1:0]  divisor;

    // Datapath helpers.
    logic [CB:0]       rng;
    logic [RANK_W-1:0] s_map;
    logic              ren_stop, ren_out0, ren_out1, ren_mid;
    logic              emit_en, emit_val, push_en;
    logic [BYTE_W-1:0] packed_byte, push_val;
    logic [CNT_W:0]    inc_half;
    logic [CNT_W-1:0]  half_cnt;
    logic              accept, load_out, out_final;
    logic              byte_ok;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);
    assign byte_ok = {1'b0, s_data_byte} < (BYTE_W + 1)'(ALPHABET);

    // Interval range and the divisor; a zero total divides as one.
    assign rng     = {1'b0, hi_reg - lo_reg} + 1'b1;
    assign divisor = (total_reg == '0) ? CNT_W'(1) : total_reg;

    // A rank outside the byte symbols falls back to the first rank.
    assign s_map = (b2r_rdata == '0 || b2r_rdata > RANK_W'(ALPHABET))
                   ? RANK_W'(1) : b2r_rdata;

    // Renormalization decision for one step.
    assign ren_stop = (guard_reg == GUARD_MAX);
    assign ren_out0 = !ren_stop && (hi_reg < HALF_VAL);
    assign ren_out1 = !ren_stop && !ren_out0 && (lo_reg >= HALF_VAL);
    assign ren_mid  = !ren_stop && !ren_out0 && !ren_out1
                      && (lo_reg >= QTR_VAL) && (hi_reg < QTR3_VAL);

    // Bit packer: the first emitted bit ends up in bit 0 of the byte.
    assign emit_en     = (state_reg == S_EMIT) || (state_reg == S_PEND);
    assign emit_val    = (state_reg == S_PEND) ? !bit_reg : bit_reg;
    assign packed_byte = {emit_val, buf_reg[BYTE_W-1:1]};
    assign push_en     = (emit_en && cnt_reg == 3'd7)
                         || (state_reg == S_FLUSH && cnt_reg != 3'd0);
    assign push_val    = emit_en ? packed_byte : (buf_reg >> (4'd8 - {1'b0, cnt_reg}));
    assign res_we      = push_en && (res_n_reg < RES_CW'(MAX_RESULTS));
    assign res_waddr   = res_n_reg[RES_AW-1:0];
    assign res_wdata   = push_val;

    // Halving for a rescale rounds up.
    assign inc_half = ({1'b0, sc_rdata} + 1'b1) >> 1;
    assign half_cnt = inc_half[CNT_W-1:0];

    assign load_out  = (state_reg == S_OLD) && (!m_valid_reg || m_ready);
    assign out_final = (out_idx_reg == res_n_reg - 1'b1);

    assign div_start = (state_reg == S_DS1) || (state_reg == S_DS2);

    // Model memory address and write steering.
    always_comb begin
        sc_we = 1'b0;  sc_waddr = '0;  sc_wdata = '0;  sc_raddr = '0;
        cum_we = 1'b0; cum_waddr = '0; cum_wdata = '0; cum_raddr = '0;
        rb_we = 1'b0;  rb_waddr = '0;  rb_wdata = '0;  rb_raddr = '0;
        b2r_we = 1'b0; b2r_waddr = '0; b2r_wdata = '0;
        unique case (state_reg)
            S_CLR: begin
                if (int'(clr_idx_reg) < TDEPTH) begin
                    sc_we     = 1'b1;
                    sc_waddr  = clr_idx_reg[RANK_W-1:0];
                    sc_wdata  = (clr_idx_reg == '0) ? '0 : CNT_W'(1);
                    cum_we    = 1'b1;
                    cum_waddr = clr_idx_reg[RANK_W-1:0];
                    cum_wdata = CNT_W'(NSYM - int'(clr_idx_reg));
                    rb_we     = 1'b1;
                    rb_waddr  = clr_idx_reg[RANK_W-1:0];
                    rb_wdata  = BYTE_W'(int'(clr_idx_reg) + 255);
                end
                if (int'(clr_idx_reg) < B2R_DEPTH) begin
                    b2r_we    = 1'b1;
                    b2r_waddr = clr_idx_reg[BYTE_W-1:0];
                    b2r_wdata = RANK_W'(int'(clr_idx_reg) + 1);
                end
            end
            S_RC0:    cum_raddr = s_reg - 1'b1;
            S_RC1:    cum_raddr = s_reg;
            S_RSC_RD: sc_raddr = k_reg;
            S_RSC_WR: begin
                sc_raddr  = k_reg - 1'b1;
                sc_we     = 1'b1;
                sc_waddr  = k_reg;
                sc_wdata  = half_cnt;
                cum_we    = 1'b1;
                cum_waddr = k_reg;
                cum_wdata = acc_reg;
            end
            S_SCR:   sc_raddr = s_reg;
            S_SCW:   sc_raddr = s_reg - 1'b1;
            S_WALK:  sc_raddr = cur_reg - RANK_W'(2);
            S_SW_R1: rb_raddr = cur_reg;
            S_SW_R2: rb_raddr = s_reg;
            S_SW_W1: begin
                rb_we     = 1'b1;
                rb_waddr  = cur_reg;
                rb_wdata  = rb_rdata;
                b2r_we    = 1'b1;
                b2r_waddr = bi_reg;
                b2r_wdata = s_reg;
            end
            S_SW_W2: begin
                rb_we     = 1'b1;
                rb_waddr  = s_reg;
                rb_wdata  = bi_reg;
                b2r_we    = 1'b1;
                b2r_waddr = bs_reg;
                b2r_wdata = cur_reg;
            end
            S_SCINC: begin
                sc_we     = 1'b1;
                sc_waddr  = cur_reg;
                sc_wdata  = sc_s_reg + 1'b1;
                cum_raddr = cur_reg - 1'b1;
            end
            S_INC: begin
                cum_we    = 1'b1;
                cum_waddr = idx_reg;
                cum_wdata = cum_rdata + 1'b1;
                cum_raddr = idx_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR: begin
                if (int'(clr_idx_reg) == CLR_LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_op == OP_DATA) begin
                        if (byte_ok) state_next = S_MAP;
                    end else if (seen_reg) begin
                        state_next = S_RC0;
                    end else begin
                        state_next = S_CLR;
                    end
                end
            end
            S_MAP:  state_next = S_MAPW;
            S_MAPW: state_next = S_RC0;
            S_RC0:  state_next = S_RC1;
            S_RC1:  state_next = S_RC2;
            S_RC2:  state_next = S_RC3;
            S_RC3:  state_next = S_MUL1;
            S_MUL1: state_next = S_DS1;
            S_DS1:  state_next = S_DW1;
            S_DW1: begin
                if (div_done) state_next = S_MUL2;
            end
            S_MUL2: state_next = S_DS2;
            S_DS2:  state_next = S_DW2;
            S_DW2: begin
                if (div_done) state_next = S_INT;
            end
            S_INT:  state_next = S_REN;
            S_REN: begin
                if (ren_out0 || ren_out1) begin
                    state_next = S_EMIT;
                end else if (!ren_mid) begin
                    state_next = (op_reg == OP_FINISH) ? S_FADD : S_UPD;
                end
            end
            S_EMIT: begin
                if (pend_reg != '0)  state_next = S_PEND;
                else if (fin_emit_reg) state_next = S_FLUSH;
                else                   state_next = S_REN;
            end
            S_PEND: begin
                if (pend_reg == PEND_W'(1)) state_next = fin_emit_reg ? S_FLUSH : S_REN;
            end
            S_FADD: state_next = S_EMIT;
            S_FLUSH: state_next = S_ORD;
            S_UPD: state_next = (total_reg >= CNT_W'(FREQ_LIMIT)) ? S_RSC_RD : S_SCR;
            S_RSC_RD: state_next = S_RSC_WR;
            S_RSC_WR: begin
                if (k_reg == '0) state_next = S_SCR;
            end
            S_SCR: state_next = S_SCW;
            S_SCW: state_next = (s_reg > RANK_W'(1)) ? S_WALK : S_SW;
            S_WALK: begin
                if (sc_rdata != sc_s_reg || cur_reg <= RANK_W'(2)) state_next = S_SW;
            end
            S_SW:    state_next = (cur_reg < s_reg) ? S_SW_R1 : S_SCINC;
            S_SW_R1: state_next = S_SW_R2;
            S_SW_R2: state_next = S_SW_W1;
            S_SW_W1: state_next = S_SW_W2;
            S_SW_W2: state_next = S_SCINC;
            S_SCINC: state_next = S_INC;
            S_INC: begin
                if (idx_reg == '0) state_next = S_ORD;
            end
            S_ORD: begin
                if (res_n_reg == '0) state_next = (op_reg == OP_FINISH) ? S_CLR : S_IDLE;
                else                 state_next = S_OLD;
            end
            S_OLD: begin
                if (load_out) begin
                    if (out_final) state_next = (op_reg == OP_FINISH) ? S_CLR : S_IDLE;
                    else           state_next = S_ORD;
                end
            end
            default: state_next = S_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out)                   m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;

            // Scalar coder state follows the model through a clearing pass.
            if (state_reg == S_CLR) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                lo_reg      <= '0;
                hi_reg      <= TOP_VAL;
                pend_reg    <= '0;
                buf_reg     <= '0;
                cnt_reg     <= '0;
                seen_reg    <= 1'b0;
                ovf_reg     <= 1'b0;
                res_n_reg   <= '0;
            end
            if (state_next == S_CLR && state_reg != S_CLR) clr_idx_reg <= '0;

            // Emitted bits go into the packer; full bytes go to the result buffer.
            if (emit_en) begin
                buf_reg <= (cnt_reg == 3'd7) ? '0 : packed_byte;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (res_we) res_n_reg <= res_n_reg + 1'b1;

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg       <= s_op;
                        byte_reg     <= s_data_byte;
                        res_n_reg    <= '0;
                        fin_emit_reg <= 1'b0;
                        s_reg        <= NSYM_R;
                        if (s_op == OP_DATA && byte_ok) seen_reg <= 1'b1;
                    end
                end
                S_MAPW: s_reg <= s_map;
                S_RC1:  c_prev_reg <= cum_rdata;
                S_RC2:  c_cur_reg  <= cum_rdata;
                S_RC3:  total_reg  <= cum_rdata;
                S_MUL1: prod_reg <= PROD_W'(rng) * PROD_W'(c_prev_reg);
                S_DW1: begin
                    if (div_done) q1_reg <= div_quot[CB-1:0];
                end
                S_MUL2: prod_reg <= PROD_W'(rng) * PROD_W'(c_cur_reg);
                S_DW2: begin
                    if (div_done) q2_reg <= div_quot[CB-1:0];
                end
                S_INT: begin
                    hi_reg    <= lo_reg + q1_reg - 1'b1;
                    lo_reg    <= lo_reg + q2_reg;
                    guard_reg <= '0;
                end
                S_REN: begin
                    if (ren_out0) begin
                        bit_reg   <= 1'b0;
                        lo_reg    <= {lo_reg[CB-2:0], 1'b0};
                        hi_reg    <= {hi_reg[CB-2:0], 1'b1};
                        guard_reg <= guard_reg + 1'b1;
                    end else if (ren_out1) begin
                        bit_reg   <= 1'b1;
                        lo_reg    <= {lo_reg[CB-2:0], 1'b0};
                        hi_reg    <= {hi_reg[CB-2:0], 1'b1};
                        guard_reg <= guard_reg + 1'b1;
                    end else if (ren_mid) begin
                        if (pend_reg < PEND_W'(PENDING_LIMIT)) pend_reg <= pend_reg + 1'b1;
                        else                                   ovf_reg  <= 1'b1;
                        lo_reg    <= {lo_reg[CB-2:0] - QTR_VAL[CB-2:0], 1'b0};
                        hi_reg    <= {hi_reg[CB-2:0] - QTR_VAL[CB-2:0], 1'b1};
                        guard_reg <= guard_reg + 1'b1;
                    end
                end
                S_PEND: pend_reg <= pend_reg - 1'b1;
                S_FADD: begin
                    if (pend_reg < PEND_W'(PENDING_LIMIT)) pend_reg <= pend_reg + 1'b1;
                    else                                   ovf_reg  <= 1'b1;
                    bit_reg      <= (lo_reg < QTR_VAL) ? 1'b0 : 1'b1;
                    fin_emit_reg <= 1'b1;
                end
                S_FLUSH: begin
                    buf_reg <= '0;
                    cnt_reg <= '0;
                end
                S_UPD: begin
                    k_reg   <= NSYM_R;
                    acc_reg <= '0;
                end
                S_RSC_WR: begin
                    acc_reg <= acc_reg + half_cnt;
                    k_reg   <= k_reg - 1'b1;
                end
                S_SCW: begin
                    sc_s_reg <= sc_rdata;
                    cur_reg  <= s_reg;
                end
                S_WALK: begin
                    if (sc_rdata == sc_s_reg) cur_reg <= cur_reg - 1'b1;
                end
                S_SW_R2: bi_reg <= rb_rdata;
                S_SW_W1: bs_reg <= rb_rdata;
                S_SCINC: idx_reg <= cur_reg - 1'b1;
                S_INC:   idx_reg <= idx_reg - 1'b1;
                S_ORD: begin
                end
                S_OLD: begin
                    if (load_out) begin
                        m_out_byte_reg <= res_rdata;
                        m_last_reg     <= (op_reg == OP_FINISH) && out_final;
                        m_ovf_reg      <= ovf_reg;
                        out_idx_reg    <= out_idx_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (state_reg == S_FLUSH || state_reg == S_INC) out_idx_reg <= '0;
        end
    end

    aae_ram #(.WIDTH(CNT_W), .DEPTH(TDEPTH)) u_sym_cnt (
        .aclk(aclk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
        .raddr(sc_raddr), .rdata(sc_rdata)
    );

    aae_ram #(.WIDTH(CNT_W), .DEPTH(TDEPTH)) u_cum_cnt (
        .aclk(aclk), .we(cum_we), .waddr(cum_waddr), .wdata(cum_wdata),
        .raddr(cum_raddr), .rdata(cum_rdata)
    );

    aae_ram #(.WIDTH(BYTE_W), .DEPTH(TDEPTH)) u_rank_byte (
        .aclk(aclk), .we(rb_we), .waddr(rb_waddr), .wdata(rb_wdata),
        .raddr(rb_raddr), .rdata(rb_rdata)
    );

    aae_ram #(.WIDTH(RANK_W), .DEPTH(B2R_DEPTH)) u_byte_rank (
        .aclk(aclk), .we(b2r_we), .waddr(b2r_waddr), .wdata(b2r_wdata),
        .raddr(byte_reg), .rdata(b2r_rdata)
    );

    aae_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_RESULTS)) u_result_buf (
        .aclk(aclk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(out_idx_reg[RES_AW-1:0]), .rdata(res_rdata)
    );

    aae_div #(.DVD_W(PROD_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(prod_reg),
        .divisor(divisor), .done(div_done), .quotient(div_quot)
    );

    assign m_valid            = m_valid_reg;
    assign m_out_byte         = m_out_byte_reg;
    assign m_last             = m_last_reg;
    assign m_pending_overflow = m_ovf_reg;

endmodule

[design/aae_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module aae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/aae_div.sv]
// Restoring divider, one quotient bit per cycle, for the interval narrowing.
// Depends on aae_pkg for the count width.
module aae_div
    import aae_pkg::*;
#(
    parameter int DVD_W = 31
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic                done,
    output logic [DVD_W-1:0]    quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                cnt_reg  <= CW'(DVD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the adaptive arithmetic encoder core.
// Depends on aae_pkg and adaptive_arithmetic_encoder_core; needs no files or arguments.
module testbench;
    import aae_pkg::*;

    localparam int SYMS = 257;          // byte symbols plus the end symbol
    localparam int FREQ_MAX = 16383;
    localparam int PEND_MAX = 255;
    localparam int TOP = 16'hFFFF;
    localparam int HALF = 32768;
    localparam int QTR = 16384;
    localparam int QTR3 = 49152;
    localparam int WATCHDOG = 30000;
    localparam int DRAIN = 400;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
    } enc_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              last;
        logic              ovf;
    } code_byte_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_op = OP_DATA;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic              m_ready = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last;
    logic              m_pending_overflow;

    always #4 aclk = ~aclk;

    adaptive_arithmetic_encoder_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_last(m_last), .m_pending_overflow(m_pending_overflow)
    );

    // Pending stimulus, expected code bytes and run status.
    enc_item_t  pending_items[$];
    code_byte_t expected_codes[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_toggle = 1'b0;
    logic       in_taken = 1'b0;

    // Shadow copy of the encoder's model and coder state.
    int         freq[0:SYMS];
    int         cum[0:SYMS];
    int         rank_byte[0:SYMS];
    int         byte_rank[0:255];
    int         lo_q, hi_q, pend_q, pbuf_q, pcnt_q;
    bit         seen_q, ovf_q;
    int         item_codes[$];

    function automatic void model_clear();
        for (int r = 0; r <= SYMS; r++) begin
            freq[r] = 1;
            cum[r] = SYMS - r;
            rank_byte[r] = (r + 255) & 8'hFF;
        end
        freq[0] = 0;
        for (int b = 0; b < 256; b++) byte_rank[b] = b + 1;
        lo_q = 0;
        hi_q = TOP;
        pend_q = 0;
        pbuf_q = 0;
        pcnt_q = 0;
        seen_q = 0;
        ovf_q = 0;
    endfunction

    function automatic void put_bit(int b);
        pbuf_q = (pbuf_q >> 1) | (b ? 8'h80 : 0);
        pcnt_q++;
        if (pcnt_q == 8) begin
            if (item_codes.size() < MAX_RESULTS) item_codes.insert(item_codes.size(), pbuf_q);
            pbuf_q = 0;
            pcnt_q = 0;
        end
    endfunction

    function automatic void put_bit_plus_pending(int b);
        put_bit(b);
        while (pend_q > 0) begin
            put_bit(!b);
            pend_q--;
        end
    endfunction

    function automatic void note_underflow();
        if (pend_q < PEND_MAX) pend_q++;
        else ovf_q = 1;
    endfunction

    function automatic void narrow_interval(int s);
        longint range, total, nl, nh;
        range = ((hi_q - lo_q) & TOP) + 1;
        total = (cum[0] != 0) ? cum[0] : 1;
        nh = (lo_q + range * cum[s-1] / total - 1) & TOP;
        nl = (lo_q + range * cum[s] / total) & TOP;
        for (int g = 0; g < 18; g++) begin
            if (nh < HALF) begin
                put_bit_plus_pending(0);
            end else if (nl >= HALF) begin
                put_bit_plus_pending(1);
                nl -= HALF;
                nh -= HALF;
            end else if (nl >= QTR && nh < QTR3) begin
                note_underflow();
                nl -= QTR;
                nh -= QTR;
            end else begin
                break;
            end
            nl = (nl << 1) & TOP;
            nh = ((nh << 1) | 1) & TOP;
        end
        lo_q = int'(nl);
        hi_q = int'(nh);
    endfunction

    function automatic void adapt_model(int s);
        int i, acc, bi, bs;
        if (cum[0] >= FREQ_MAX) begin
            acc = 0;
            for (int k = SYMS; k >= 0; k--) begin
                freq[k] = (freq[k] + 1) / 2;
                cum[k] = acc;
                acc += freq[k];
            end
        end
        i = s;
        while (i > 1 && freq[i] == freq[i-1]) i--;
        // Move the symbol to the lowest rank sharing its count before bumping it.
        if (i < s) begin
            bi = rank_byte[i];
            bs = rank_byte[s];
            rank_byte[i] = bs;
            rank_byte[s] = bi;
            byte_rank[bi] = s;
            byte_rank[bs] = i;
        end
        freq[i]++;
        while (i > 0) begin
            i--;
            cum[i]++;
        end
    endfunction

    // Works out the code bytes that one accepted transaction produces.
    function automatic void predict_codes(enc_item_t it);
        int s;
        code_byte_t c;
        bit finishing;
        item_codes.delete();
        finishing = (it.op == OP_FINISH);
        if (!finishing) begin
            seen_q = 1;
            s = byte_rank[it.data];
            if (s < 1 || s > 256) s = 1;
            narrow_interval(s);
            adapt_model(s);
        end else if (seen_q) begin
            narrow_interval(SYMS);
            note_underflow();
            put_bit_plus_pending(lo_q < QTR ? 0 : 1);
            if (pcnt_q > 0 && item_codes.size() < MAX_RESULTS)
                item_codes.insert(item_codes.size(), pbuf_q >> (8 - pcnt_q));
        end
        foreach (item_codes[k]) begin
            c.code = item_codes[k][7:0];
            c.ovf = ovf_q;
            c.last = finishing && (k == item_codes.size() - 1);
            expected_codes.insert(expected_codes.size(), c);
        end
        if (finishing) model_clear();
    endfunction

    // Driver: presents the next transaction at the falling edge once the last one went in.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                enc_item_t it;
                it = pending_items.pop_front();
                s_op <= it.op;
                s_data_byte <= it.data;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    bit hold_seen = 1'b0;
    int hold_left = 0;
    always @(negedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= 1500;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on each accepted input transaction and checks each output one.
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready) predict_codes(enc_item_t'{op: s_op, data: s_data_byte});
            if (m_valid && m_ready) begin
                if (expected_codes.size() == 0) begin
                    $error("unexpected code byte %0h", m_out_byte);
                    errors++;
                end else begin
                    code_byte_t e;
                    e = expected_codes.pop_front();
                    if (m_out_byte !== e.code) begin
                        $error("out_byte: expected %0h, got %0h", e.code, m_out_byte);
                        errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0b, got %0b", e.last, m_last);
                        errors++;
                    end
                    if (m_pending_overflow !== e.ovf) begin
                        $error("pending_overflow: expected %0b, got %0b",
                               e.ovf, m_pending_overflow);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic void add_item(logic op, int data);
        pending_items.insert(pending_items.size(), enc_item_t'{op: op, data: data[7:0]});
    endfunction

    // Mostly bytes from a small skewed set so the ranks keep moving, some noise,
    // and now and then a finish that closes the stream.
    function automatic void add_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(13) == 0) add_item(OP_FINISH, $urandom_range(255));
            else if ($urandom_range(9) < 7) add_item(OP_DATA, 8'h40 + $urandom_range(3));
            else add_item(OP_DATA, $urandom_range(255));
        end
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_codes.size() > 0)
            @(posedge aclk);
        // A finish may still be clearing the model after its last byte left.
        repeat (DRAIN) @(posedge aclk);
    endtask

    initial begin
        model_clear();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: finish with nothing coded, the byte extremes, repeats that reorder
        // the ranks, a finish, and a finish on an empty stream right after it.
        add_item(OP_FINISH, 8'h00);
        add_item(OP_DATA, 8'h00);
        add_item(OP_DATA, 8'hFF);
        add_item(OP_DATA, 8'h55);
        add_item(OP_DATA, 8'hAA);
        for (int i = 0; i < 8; i++) add_item(OP_DATA, 8'h7F);
        add_item(OP_DATA, 8'h80);
        add_item(OP_DATA, 8'hFF);
        add_item(OP_DATA, 8'hFF);
        add_item(OP_FINISH, 8'hFF);
        add_item(OP_FINISH, 8'h00);
        add_item(OP_DATA, 8'h01);
        add_item(OP_FINISH, 8'h00);
        wait_idle();

        add_random(27);
        wait_idle();
        send_idle_pct = 56;
        add_random(27);
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 56;
        add_random(27);
        wait_idle();
        send_idle_pct = 35;
        recv_stall_pct = 35;
        add_random(27);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering, so the input stalls.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_toggle = ~hold_toggle;
        add_random(12);
        add_item(OP_FINISH, 8'h00);
        wait_idle();

        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/aae_pkg.sv
design/aae_ram.sv
design/aae_div.sv
design/adaptive_arithmetic_encoder_core.sv
dv/testbench.sv
